### hdl/euler_to_quaternion_macros.svh
// Assertion macros shared by the euler_to_quaternion RTL
`ifndef EULER_TO_QUATERNION_MACROS_SVH
`define EULER_TO_QUATERNION_MACROS_SVH

// same-cycle implication, disabled in reset
`define E2Q_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define E2Q_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/e2q_pkg.sv
// Constants and tables for the Euler angle to quaternion converter
package e2q_pkg;

  localparam int ANGLE_WIDTH_DEF     = 16;
  localparam int COMPONENT_WIDTH_DEF = 16;

  localparam int          FRAC   = 30;
  localparam logic [63:0] ONE_Q  = 64'd1 << FRAC;
  localparam logic [63:0] HALF_Q = 64'd1 << (FRAC - 1);
  localparam logic [31:0] PI_Q   = 32'd3373259426;

  localparam int HORNER_STEPS = 7;
  localparam int STEP_STAGES  = 4;
  localparam int SC_LAT       = 4 + HORNER_STEPS * STEP_STAGES + 2;

  localparam int LANE_SIN = 0;
  localparam int LANE_COS = 1;

  localparam logic [7:0] SIN_DIV [HORNER_STEPS] = '{8'd210, 8'd156, 8'd110, 8'd72,
                                                    8'd42, 8'd20, 8'd6};
  localparam logic [7:0] COS_DIV [HORNER_STEPS] = '{8'd182, 8'd132, 8'd90, 8'd56,
                                                    8'd30, 8'd12, 8'd2};

  function automatic logic [7:0] e2q_div(input int lane, input int step);
    return (lane == LANE_SIN) ? SIN_DIV[step] : COS_DIV[step];
  endfunction

endpackage

### hdl/euler_to_quaternion.sv
// Top level: Euler angles (bank, heading, attitude) to unit quaternion
//
//   channel  dir  fields (low bit first)
//   in_*     in   tdata: bank_angle, heading_angle, attitude_angle
//   out_*    out  tdata: quat_w, quat_x, quat_y, quat_z
//
// One word per cycle enters while the output is not stalled; each word
// passes the sine-cosine pipeline, two product levels with rounding, the
// sum and output register. The Horner multiply chain is fully pipelined.
// rst_n clears the valid bits only. A stalled output holds its word and
// the pipeline keeps filling until a valid word reaches its last stage.
`include "euler_to_quaternion_macros.svh"

module euler_to_quaternion #(
  parameter int ANGLE_WIDTH     = e2q_pkg::ANGLE_WIDTH_DEF,
  parameter int COMPONENT_WIDTH = e2q_pkg::COMPONENT_WIDTH_DEF,
  parameter int IN_DW  = ((3 * ANGLE_WIDTH + 7) / 8) * 8,
  parameter int OUT_DW = ((4 * COMPONENT_WIDTH + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // bank_angle, heading_angle, attitude_angle
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata   // quat_w, quat_x, quat_y, quat_z
);
  import e2q_pkg::*;

  localparam int CW     = COMPONENT_WIDTH;
  localparam int LAT    = SC_LAT + 5;
  localparam int SH     = (CW < 31) ? 31 - CW : 1;
  localparam int TRI_PAIR [8] = '{0, 1, 1, 0, 2, 3, 3, 2};

  logic           en;
  logic [LAT-1:0] vld_r;
  logic           out_valid_r;
  logic [4*CW-1:0] out_data_r;

  logic signed [31:0] s1, c1, s2, c2, s3, c3;
  logic signed [31:0] pa [4];
  logic signed [31:0] pb [4];

  logic [63:0] pm1_r [4];
  logic        psg1_r [4];
  logic signed [31:0] c3_1_r, s3_1_r, c3_2_r, s3_2_r;
  logic signed [31:0] pair_r [4];
  logic [63:0] tm_r [8];
  logic        tsg_r [8];
  logic signed [31:0] tri_r [8];
  logic signed [33:0] sum_r [4];
  logic [4*CW-1:0] comp;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic signed [31:0] rnd(input logic [63:0] p, input logic sg);
    logic [31:0] m;
    m = 32'((p + HALF_Q) >> FRAC);
    return sg ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [CW-1:0] to_comp(input logic signed [33:0] v);
    logic [35:0] m;
    logic [35:0] lim;
    m   = v[33] ? 36'(-v) : 36'(v);
    lim = 36'd1 << (CW - 1);
    if (CW < 31) begin
      m = (m + (36'd1 << (SH - 1))) >> SH;
    end else if (CW > 31) begin
      m = m << 1;
    end
    if (v[33]) begin
      if (m > lim) begin
        m = lim;
      end
      return CW'(-m);
    end
    if (m > lim - 36'd1) begin
      m = lim - 36'd1;
    end
    return CW'(m);
  endfunction

  assign en        = !(out_valid_r && !out_tready && vld_r[LAT-1]);
  assign in_tready = en;

  e2q_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_bank (
    .clk(clk), .en(en), .angle(in_tdata[0 +: ANGLE_WIDTH]), .sin_o(s3), .cos_o(c3)
  );
  e2q_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_heading (
    .clk(clk), .en(en), .angle(in_tdata[ANGLE_WIDTH +: ANGLE_WIDTH]), .sin_o(s1), .cos_o(c1)
  );
  e2q_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_attitude (
    .clk(clk), .en(en), .angle(in_tdata[2*ANGLE_WIDTH +: ANGLE_WIDTH]), .sin_o(s2), .cos_o(c2)
  );

  assign pa[0] = c1; assign pb[0] = c2;
  assign pa[1] = s1; assign pb[1] = s2;
  assign pa[2] = s1; assign pb[2] = c2;
  assign pa[3] = c1; assign pb[3] = s2;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      comp[i*CW +: CW] = to_comp(sum_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        pm1_r[i]  <= 64'(mag32(pa[i])) * 64'(mag32(pb[i]));
        psg1_r[i] <= pa[i][31] ^ pb[i][31];
        pair_r[i] <= rnd(pm1_r[i], psg1_r[i]);
      end
      c3_1_r <= c3;
      s3_1_r <= s3;
      c3_2_r <= c3_1_r;
      s3_2_r <= s3_1_r;
      for (int k = 0; k < 8; k++) begin
        if (k % 2 == 0) begin
          tm_r[k]  <= 64'(mag32(pair_r[TRI_PAIR[k]])) * 64'(mag32(c3_2_r));
          tsg_r[k] <= pair_r[TRI_PAIR[k]][31] ^ c3_2_r[31];
        end else begin
          tm_r[k]  <= 64'(mag32(pair_r[TRI_PAIR[k]])) * 64'(mag32(s3_2_r));
          tsg_r[k] <= pair_r[TRI_PAIR[k]][31] ^ s3_2_r[31];
        end
        tri_r[k] <= rnd(tm_r[k], tsg_r[k]);
      end
      sum_r[0] <= 34'(tri_r[0]) - 34'(tri_r[1]);
      sum_r[1] <= 34'(tri_r[2]) + 34'(tri_r[3]);
      sum_r[2] <= 34'(tri_r[4]) + 34'(tri_r[5]);
      sum_r[3] <= 34'(tri_r[6]) - 34'(tri_r[7]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (en) begin
        vld_r <= {vld_r[LAT-2:0], in_tvalid};
      end
      if (!out_valid_r || out_tready) begin
        out_valid_r <= vld_r[LAT-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      out_data_r <= comp;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DW'(out_data_r);

  `E2Q_ASSERT_IMP(a_stall_only_full, clk, rst_n, !in_tready, out_tvalid && !out_tready && vld_r[LAT-1], "input stalled without a blocked result")
  `E2Q_ASSERT_NXT(a_last_held, clk, rst_n, vld_r[LAT-1] && !en, vld_r[LAT-1], "stalled last stage lost its word")
  `E2Q_ASSERT_IMP(a_out_from_pipe, clk, rst_n, $rose(out_tvalid), $past(vld_r[LAT-1]), "result without a valid last stage")

endmodule

### hdl/e2q_sincos.sv
// Pipelined sine and cosine of a half binary angle, Q2.30 results
module e2q_sincos #(
  parameter int ANGLE_WIDTH = e2q_pkg::ANGLE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [ANGLE_WIDTH-1:0] angle,
  output logic signed [31:0]     sin_o,
  output logic signed [31:0]     cos_o
);
  import e2q_pkg::*;

  logic [31:0] a32;
  logic [31:0] mag;
  logic        neg;

  logic [63:0] p1_r;
  logic        neg1_r, neg2_r, neg3_r, neg4_r;
  logic [30:0] t2s_r, t3s_r, t4s_r;
  logic [61:0] p3_r;
  logic [31:0] t2_r;

  logic [31:0] t2_q  [HORNER_STEPS+1];
  logic [30:0] t_q   [HORNER_STEPS+1];
  logic        neg_q [HORNER_STEPS+1];
  logic [30:0] r_q   [2][HORNER_STEPS+1];

  logic [61:0] ps_r;
  logic        negf_r;
  logic [30:0] cf_r;
  logic [30:0] sn;
  logic signed [31:0] sin_r, cos_r;

  assign a32 = 32'(unsigned'(angle)) << (32 - ANGLE_WIDTH);
  assign neg = a32[31];
  assign mag = neg ? (~a32 + 32'd1) : a32;

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r   <= 64'(mag) * 64'(PI_Q);
      neg1_r <= neg;
      t2s_r  <= 31'((p1_r + (64'd1 << 31)) >> 32);
      neg2_r <= neg1_r;
      p3_r   <= 62'(t2s_r) * 62'(t2s_r);
      t3s_r  <= t2s_r;
      neg3_r <= neg2_r;
      t2_r   <= 32'((64'(p3_r) + HALF_Q) >> FRAC);
      t4s_r  <= t3s_r;
      neg4_r <= neg3_r;
    end
  end

  assign t2_q[0]  = t2_r;
  assign t_q[0]   = t4s_r;
  assign neg_q[0] = neg4_r;
  assign r_q[LANE_SIN][0] = 31'(ONE_Q);
  assign r_q[LANE_COS][0] = 31'(ONE_Q);

  for (genvar k = 0; k < HORNER_STEPS; k++) begin : g_step
    logic [31:0] t2_s  [STEP_STAGES];
    logic [30:0] t_s   [STEP_STAGES];
    logic        neg_s [STEP_STAGES];

    always_ff @(posedge clk) begin
      if (en) begin
        t2_s[0]  <= t2_q[k];
        t_s[0]   <= t_q[k];
        neg_s[0] <= neg_q[k];
        for (int i = 1; i < STEP_STAGES; i++) begin
          t2_s[i]  <= t2_s[i-1];
          t_s[i]   <= t_s[i-1];
          neg_s[i] <= neg_s[i-1];
        end
      end
    end

    assign t2_q[k+1]  = t2_s[STEP_STAGES-1];
    assign t_q[k+1]   = t_s[STEP_STAGES-1];
    assign neg_q[k+1] = neg_s[STEP_STAGES-1];

    for (genvar j = 0; j < 2; j++) begin : g_lane
      localparam logic [7:0]  D = e2q_div(j, k);
      localparam logic [31:0] M = 32'((64'd1 << 32) / 64'(D));

      logic [62:0] pa_r;
      logic [31:0] xb_r, xc_r;
      logic [63:0] pb_r;
      logic [31:0] q0c_r;
      logic [39:0] qd_r;
      logic [30:0] rd_r;
      logic [31:0] x_b;
      logic [39:0] rem;
      logic [32:0] q;

      assign x_b = 32'(pa_r >> FRAC) + 32'(D >> 1);
      assign rem = {8'd0, xc_r} - qd_r;
      assign q   = (rem >= 40'(D)) ? 33'(q0c_r) + 33'd1 : 33'(q0c_r);

      always_ff @(posedge clk) begin
        if (en) begin
          pa_r  <= 63'(t2_q[k]) * 63'(r_q[j][k]);
          xb_r  <= x_b;
          pb_r  <= 64'(x_b) * 64'(M);
          xc_r  <= xb_r;
          q0c_r <= pb_r[63:32];
          qd_r  <= 40'(pb_r[63:32]) * 40'(D);
          rd_r  <= (q > 33'(ONE_Q)) ? 31'd0 : 31'(33'(ONE_Q) - q);
        end
      end

      assign r_q[j][k+1] = rd_r;
    end
  end

  assign sn = 31'((64'(ps_r) + HALF_Q) >> FRAC);

  always_ff @(posedge clk) begin
    if (en) begin
      ps_r   <= 62'(t_q[HORNER_STEPS]) * 62'(r_q[LANE_SIN][HORNER_STEPS]);
      negf_r <= neg_q[HORNER_STEPS];
      cf_r   <= r_q[LANE_COS][HORNER_STEPS];
      sin_r  <= negf_r ? -$signed({1'b0, sn}) : $signed({1'b0, sn});
      cos_r  <= $signed({1'b0, cf_r});
    end
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule

### sim/tb.sv
// Testbench for euler_to_quaternion: self-checking stream test with a fixed-point predictor
`timescale 1ns / 100ps

module tb;

  localparam int AW = 16;
  localparam int CW = 16;
  localparam int LAT = e2q_pkg::SC_LAT + 6;
  localparam longint LIMIT = 400000;

  typedef struct packed {
    logic signed [15:0] z;
    logic signed [15:0] y;
    logic signed [15:0] x;
    logic signed [15:0] w;
  } quat_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [47:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [63:0] out_tdata;

  quat_t quat_q[$];
  int errors = 0;
  int n_sent = 0;
  int n_recv = 0;
  longint cycles = 0;
  bit rx_idle_en;
  bit tx_idle_en;
  bit long_hold_req = 1'b0;
  bit long_hold_done = 1'b0;
  int hold_off = 0;

  euler_to_quaternion u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [63:0] series(logic [63:0] t2, bit cos_lane);
    logic [63:0] r;
    logic [63:0] d;
    logic [63:0] term;
    r = e2q_pkg::ONE_Q;
    for (int k = 0; k < e2q_pkg::HORNER_STEPS; k++) begin
      d = cos_lane ? 64'(e2q_pkg::COS_DIV[k]) : 64'(e2q_pkg::SIN_DIV[k]);
      term = (t2 * r + d * e2q_pkg::HALF_Q) / (d * e2q_pkg::ONE_Q);
      r = (term > e2q_pkg::ONE_Q) ? 64'd0 : e2q_pkg::ONE_Q - term;
    end
    return r;
  endfunction

  function automatic void half_angle(input logic [15:0] ang, output longint s,
                                     output longint c);
    logic [63:0] a32;
    logic [63:0] m;
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] sn;
    a32 = {32'd0, ang, 16'd0};
    m = a32[31] ? (64'd1 << 32) - a32 : a32;
    t = (m * 64'(e2q_pkg::PI_Q) + (64'd1 << 31)) >> 32;
    t2 = (t * t + e2q_pkg::HALF_Q) >> e2q_pkg::FRAC;
    sn = (t * series(t2, 1'b0) + e2q_pkg::HALF_Q) >> e2q_pkg::FRAC;
    c = longint'(series(t2, 1'b1));
    s = a32[31] ? -longint'(sn) : longint'(sn);
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    logic [63:0] p;
    bit neg;
    neg = (a < 0) != (b < 0);
    p = (64'(a < 0 ? -a : a) * 64'(b < 0 ? -b : b) + e2q_pkg::HALF_Q) >> e2q_pkg::FRAC;
    return neg ? -longint'(p) : longint'(p);
  endfunction

  function automatic logic [15:0] saturate(longint v);
    longint m;
    m = v < 0 ? -v : v;
    m = (m + (64'd1 << 14)) >> 15;
    if (v < 0) begin
      if (m > 32768) m = 32768;
      return 16'(-m);
    end
    if (m > 32767) m = 32767;
    return 16'(m);
  endfunction

  function automatic quat_t to_quat(logic [15:0] bank, logic [15:0] head, logic [15:0] att);
    longint s1, c1, s2, c2, s3, c3;
    quat_t q;
    half_angle(bank, s3, c3);
    half_angle(head, s1, c1);
    half_angle(att, s2, c2);
    q.w = saturate(fx_mul(fx_mul(c1, c2), c3) - fx_mul(fx_mul(s1, s2), s3));
    q.x = saturate(fx_mul(fx_mul(s1, s2), c3) + fx_mul(fx_mul(c1, c2), s3));
    q.y = saturate(fx_mul(fx_mul(s1, c2), c3) + fx_mul(fx_mul(c1, s2), s3));
    q.z = saturate(fx_mul(fx_mul(c1, s2), c3) - fx_mul(fx_mul(s1, c2), s3));
    return q;
  endfunction

  task automatic send_angles(input logic [15:0] bank, input logic [15:0] head,
                             input logic [15:0] att);
    int gap;
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {att, head, bank};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    quat_q.push_back(to_quat(bank, head, att));
    n_sent++;
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (quat_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed;
    logic [15:0] ext[8] = '{16'h0000, 16'h8000, 16'h7FFF, 16'h4000, 16'hC000,
                            16'h0001, 16'hFFFF, 16'h2000};
    for (int i = 0; i < 8; i++) send_angles(ext[i], 16'h0000, 16'h0000);
    for (int i = 0; i < 8; i++) send_angles(16'h0000, ext[i], 16'h0000);
    for (int i = 0; i < 8; i++) send_angles(16'h0000, 16'h0000, ext[i]);
    send_angles(16'h8000, 16'h8000, 16'h8000);
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++)
      send_angles(16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic test_backpressure;
    long_hold_req = 1'b1;
    for (int i = 0; i < 100; i++)
      send_angles(16'($urandom), 16'($urandom), 16'($urandom));
    drain();
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[euler_to_quaternion] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (long_hold_req && !long_hold_done) begin
      long_hold_done <= 1'b1;
      hold_off <= 200;
      out_tready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 1'b0;
    end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
      hold_off <= $urandom_range(0, 4);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    quat_t got;
    quat_t exp_q;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      n_recv++;
      if (quat_q.size() == 0) begin
        $error("unexpected word %h", out_tdata);
        errors++;
      end else begin
        exp_q = quat_q.pop_front();
        if (got.w !== exp_q.w) begin
          $error("quat_w expected %0d actual %0d", exp_q.w, got.w);
          errors++;
        end
        if (got.x !== exp_q.x) begin
          $error("quat_x expected %0d actual %0d", exp_q.x, got.x);
          errors++;
        end
        if (got.y !== exp_q.y) begin
          $error("quat_y expected %0d actual %0d", exp_q.y, got.y);
          errors++;
        end
        if (got.z !== exp_q.z) begin
          $error("quat_z expected %0d actual %0d", exp_q.z, got.z);
          errors++;
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    rx_idle_en = 1'b1;
    tx_idle_en = 1'b1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    drain();
    test_random(700);
    test_backpressure();
    test_random(400);
    rx_idle_en = 1'b0;
    tx_idle_en = 1'b0;
    test_random(300);
    drain();
    repeat (LAT + 10) @(posedge clk);
    if (quat_q.size() != 0) begin
      $error("quaternion words missing: expected %0d actual %0d", n_sent, n_recv);
    end
    $display("Sent %0d angle triples, checked %0d quaternions,", n_sent, n_recv);
    $display("with extreme angles, random gaps, stalls and a long output hold-off.");
    if (errors == 0 && quat_q.size() == 0) begin
      $display("[euler_to_quaternion] OK");
    end else begin
      $display("[euler_to_quaternion] ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/e2q_pkg.sv
hdl/e2q_sincos.sv
hdl/euler_to_quaternion.sv
sim/tb.sv
